@@ hdl/text_console_writer_assert.svh @@
// Assertion macros used by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tcw_pkg.sv @@
// Package: types and constants of the text console writer.
package tcw_pkg;

    localparam int CMD_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int ADDR_IN_W   = 11;
    localparam int OUT_COL_W   = 7;
    localparam int OUT_ROW_W   = 5;
    localparam int OUT_LIN_W   = 11;
    localparam int CELL_W      = 16;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE      = 8'h0A;
    localparam logic [BYTE_W-1:0] BLANK_CODE        = 8'h20;
    localparam logic [BYTE_W-1:0] DEFAULT_ATTR_INIT = 8'h07;

    // register index, taken from paddr[2]
    localparam logic REG_DEFAULT_ATTR = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 3'd0,
        CMD_CLEAR = 3'd1,
        CMD_SET   = 3'd2,
        CMD_ERASE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_FILL,
        S_RDWAIT,
        S_DONE
    } t_state;

endpackage

@@ hdl/text_console_writer.sv @@
// Put w/o scroll, set cursor, erase back, unused codes: execute to done, which registers the result.
// An in-range read cell adds a read wait state after execute; the screen store read port is registered.
// A new command is accepted only in idle, after the previous result is loaded into the output register.
// Scrolling runs a row move then a blank row fill before done; clear fills every cell before done.
// Reset: synchronous, active low; cursor homed, default attribute 7, store left undefined.
// No clearing pass after reset: cells read back only once written or cleared.
`include "text_console_writer_assert.svh"

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // cmd[2:0] char_code[10:3] attribute[18:11] col[26:19] row[34:27] read_addr[45:35]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tcw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cursor_col[6:0] cursor_row[11:7] cursor_linear[22:12] cell_data[38:23] rejected[39]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tcw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] MOVE_LAST  = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BOT_FIRST  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

    tcw_pkg::t_state r_state, n_state;
    tcw_pkg::t_cmd   r_cmd;

    logic [tcw_pkg::BYTE_W-1:0]    r_code, r_attr, r_req_col, r_req_row;
    logic [tcw_pkg::ADDR_IN_W-1:0] r_addr;
    logic [COL_W-1:0]              r_col, n_col;
    logic [ROW_W-1:0]              r_row, n_row;
    logic [ADDR_W-1:0]             r_ptr, n_ptr;
    logic [ADDR_W-1:0]             r_waddr;
    logic                          r_wpend, n_wpend;
    logic                          r_rej, n_rej;
    logic [tcw_pkg::CELL_W-1:0]    r_cell, n_cell;
    logic [tcw_pkg::CELL_W-1:0]    r_rdata;
    logic                          r_ovalid;
    logic [tcw_pkg::OUT_TDATA_W-1:0] r_odata;

    logic [tcw_pkg::CELL_W-1:0]    mem_screen [CELLS];
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr, mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]    mem_wdata;

    logic [tcw_pkg::BYTE_W-1:0]    default_attr;
    logic [ADDR_W-1:0]             w_lin;
    logic                          s_accept;
    logic                          load_out;
    logic                          set_ok;
    logic                          read_ok;

    tcw_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_default_attr (default_attr)
    );

    assign w_lin    = ADDR_W'(r_row) * ROW_STRIDE + ADDR_W'(r_col);
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign set_ok   = ({1'b0, r_req_col} < 9'(COLUMNS)) && ({1'b0, r_req_row} < 9'(ROWS));
    assign read_ok  = 32'(r_addr) < 32'(CELLS);

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_ptr   = r_ptr;
        n_rej   = r_rej;
        n_cell  = r_cell;
        n_wpend = 1'b0;
        case (r_state)
            tcw_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = tcw_pkg::S_EXEC;
                end
            end
            tcw_pkg::S_EXEC: begin
                n_rej   = 1'b0;
                n_cell  = '0;
                n_state = tcw_pkg::S_DONE;
                case (r_cmd)
                    tcw_pkg::CMD_PUT: begin
                        if (r_code != tcw_pkg::NEWLINE_CODE && r_col != COL_LAST) begin
                            n_col = r_col + 1'b1;
                        end else begin
                            n_col = '0;
                            if (r_row == ROW_LAST) begin
                                n_ptr   = '0;
                                n_state = tcw_pkg::S_SCROLL;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end
                    end
                    tcw_pkg::CMD_CLEAR: begin
                        n_col   = '0;
                        n_row   = '0;
                        n_ptr   = '0;
                        n_state = tcw_pkg::S_FILL;
                    end
                    tcw_pkg::CMD_SET: begin
                        if (set_ok) begin
                            n_col = r_req_col[COL_W-1:0];
                            n_row = r_req_row[ROW_W-1:0];
                        end else begin
                            n_rej = 1'b1;
                        end
                    end
                    tcw_pkg::CMD_ERASE: begin
                        if (r_col != '0) begin
                            n_col = r_col - 1'b1;
                        end else if (r_row != '0) begin
                            n_row = r_row - 1'b1;
                            n_col = COL_LAST;
                        end
                    end
                    tcw_pkg::CMD_READ: begin
                        if (read_ok) begin
                            n_state = tcw_pkg::S_RDWAIT;
                        end
                    end
                    default: begin
                        n_state = tcw_pkg::S_DONE;
                    end
                endcase
            end
            tcw_pkg::S_SCROLL: begin
                n_wpend = 1'b1;
                if (r_ptr == MOVE_LAST) begin
                    n_ptr   = BOT_FIRST;
                    n_state = tcw_pkg::S_FILL;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            tcw_pkg::S_FILL: begin
                if (!r_wpend) begin
                    if (r_ptr == CELL_LAST) begin
                        n_state = tcw_pkg::S_DONE;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            tcw_pkg::S_RDWAIT: begin
                n_cell  = r_rdata;
                n_state = tcw_pkg::S_DONE;
            end
            tcw_pkg::S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase
    end

    // store port controls and handshake
    always_comb begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_ptr;
        mem_wdata     = {default_attr, tcw_pkg::BLANK_CODE};
        mem_raddr     = ADDR_W'(r_addr);
        case (r_state)
            tcw_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            tcw_pkg::S_EXEC: begin
                if (r_cmd == tcw_pkg::CMD_PUT && r_code != tcw_pkg::NEWLINE_CODE) begin
                    mem_we    = 1'b1;
                    mem_waddr = w_lin;
                    mem_wdata = {r_attr, r_code};
                end else if (r_cmd == tcw_pkg::CMD_ERASE) begin
                    mem_we    = 1'b1;
                    mem_waddr = (w_lin == '0) ? '0 : w_lin - 1'b1;
                    mem_wdata = {r_attr, tcw_pkg::BLANK_CODE};
                end
            end
            tcw_pkg::S_SCROLL: begin
                mem_raddr = r_ptr + ROW_STRIDE;
            end
            tcw_pkg::S_FILL: begin
                mem_we = !r_wpend;
            end
            tcw_pkg::S_DONE: begin
                load_out = !r_ovalid || m_axis_tready;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
        // row move: write back what the previous cycle read
        if (r_wpend) begin
            mem_we    = 1'b1;
            mem_waddr = r_waddr;
            mem_wdata = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_screen[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem_screen[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tcw_pkg::S_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_wpend  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_wpend <= n_wpend;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_rej   <= n_rej;
        r_cell  <= n_cell;
        r_waddr <= r_ptr;
        if (s_accept) begin
            r_cmd     <= tcw_pkg::t_cmd'(s_axis_tdata[2:0]);
            r_code    <= s_axis_tdata[10:3];
            r_attr    <= s_axis_tdata[18:11];
            r_req_col <= s_axis_tdata[26:19];
            r_req_row <= s_axis_tdata[34:27];
            r_addr    <= s_axis_tdata[45:35];
        end
        if (load_out) begin
            r_odata <= {r_rej, r_cell, tcw_pkg::OUT_LIN_W'(w_lin),
                        tcw_pkg::OUT_ROW_W'(r_row), tcw_pkg::OUT_COL_W'(r_col)};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    `TCW_ASSERT_NOW(a_cursor_range, 1'b1, (r_col <= COL_LAST) && (r_row <= ROW_LAST), "cursor off screen")
    `TCW_ASSERT_NOW(a_write_range, mem_we, mem_waddr <= CELL_LAST, "store write out of range")
    `TCW_ASSERT_NOW(a_wpend_state, r_wpend, (r_state == tcw_pkg::S_SCROLL) || (r_state == tcw_pkg::S_FILL), "row move write outside scroll")
    `TCW_ASSERT_NEXT(a_accept_exec, s_accept, r_state == tcw_pkg::S_EXEC, "accepted command not executed")
    `TCW_ASSERT_NOW(a_result_from_done, $rose(m_axis_tvalid), $past(r_state) == tcw_pkg::S_DONE, "result loaded outside done")

endmodule

@@ hdl/tcw_apb_regs.sv @@
// APB configuration register block: default attribute.
module tcw_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [tcw_pkg::BYTE_W-1:0]          o_default_attr
);

    logic [tcw_pkg::BYTE_W-1:0] r_default_attr;
    logic                       wr_default;

    assign pready     = 1'b1;
    assign wr_default = psel && penable && pwrite &&
                        (paddr[2] == tcw_pkg::REG_DEFAULT_ATTR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= tcw_pkg::DEFAULT_ATTR_INIT;
        end else if (wr_default) begin
            r_default_attr <= pwdata[tcw_pkg::BYTE_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == tcw_pkg::REG_DEFAULT_ATTR) begin
            prdata = {{(tcw_pkg::APB_DATA_W-tcw_pkg::BYTE_W){1'b0}}, r_default_attr};
        end else begin
            prdata = '0;
        end
    end

    assign o_default_attr = r_default_attr;

endmodule

@@ dv/console_checker.sv @@
// Checker: predicts cursor reports, cell reads and APB reads; compares them with the DUT.
`timescale 1ns / 100ps

module console_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_tvalid,
    input  logic                               i_cmd_tready,
    // cmd[2:0] char_code[10:3] attribute[18:11] col[26:19] row[34:27] read_addr[45:35]
    input  logic [tcw_pkg::IN_TDATA_W-1:0]     i_cmd_tdata,
    input  logic                               i_res_tvalid,
    input  logic                               i_res_tready,
    // cursor_col[6:0] cursor_row[11:7] cursor_linear[22:12] cell_data[38:23] rejected[39]
    input  logic [tcw_pkg::OUT_TDATA_W-1:0]    i_res_tdata,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic                               i_pready,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]     i_pwdata,
    input  logic [tcw_pkg::APB_DATA_W-1:0]     i_prdata,
    output int                                 o_errors,
    output int                                 o_pending
);
    import tcw_pkg::*;

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int CELL_AW = $clog2(CELLS);

    typedef struct packed {
        logic [1:0]           pad;
        logic [ADDR_IN_W-1:0] read_addr;
        logic [BYTE_W-1:0]    row;
        logic [BYTE_W-1:0]    col;
        logic [BYTE_W-1:0]    attribute;
        logic [BYTE_W-1:0]    char_code;
        logic [CMD_W-1:0]     cmd;
    } t_console_cmd;

    typedef struct packed {
        logic                 rejected;
        logic [CELL_W-1:0]    cell_data;
        logic [OUT_LIN_W-1:0] cursor_linear;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [OUT_COL_W-1:0] cursor_col;
    } t_cursor_report;

    logic [CELL_W-1:0]    screen [CELLS];
    logic [OUT_COL_W-1:0] cur_col;
    logic [OUT_ROW_W-1:0] cur_row;
    logic [BYTE_W-1:0]    blank_attr;
    t_cursor_report       expected_reports [$];

    function automatic t_cursor_report execute_command(t_console_cmd c);
        t_cursor_report     r;
        logic [CELL_AW-1:0] lin;
        r = '0;
        case (c.cmd)
            CMD_PUT: begin
                if (c.char_code == NEWLINE_CODE) begin
                    cur_row = cur_row + 1'b1;
                    cur_col = '0;
                end else begin
                    lin = CELL_AW'(cur_row * COLUMNS + cur_col);
                    screen[lin] = {c.attribute, c.char_code};
                    cur_col = cur_col + 1'b1;
                end
                if (cur_col >= COLUMNS) begin
                    cur_row = cur_row + 1'b1;
                    cur_col = '0;
                end
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen[CELL_AW'(i)] = screen[CELL_AW'(i + COLUMNS)];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen[CELL_AW'(i)] = {blank_attr, BLANK_CODE};
                    cur_row = OUT_ROW_W'(ROWS - 1);
                end
            end
            CMD_CLEAR: begin
                foreach (screen[i]) screen[i] = {blank_attr, BLANK_CODE};
                cur_col = '0;
                cur_row = '0;
            end
            CMD_SET: begin
                if (c.col < COLUMNS && c.row < ROWS) begin
                    cur_col = c.col[OUT_COL_W-1:0];
                    cur_row = c.row[OUT_ROW_W-1:0];
                end else begin
                    r.rejected = 1'b1;
                end
            end
            CMD_ERASE: begin
                if (cur_col > 0) begin
                    cur_col = cur_col - 1'b1;
                end else if (cur_row > 0) begin
                    cur_row = cur_row - 1'b1;
                    cur_col = OUT_COL_W'(COLUMNS - 1);
                end
                lin = CELL_AW'(cur_row * COLUMNS + cur_col);
                screen[lin] = {c.attribute, BLANK_CODE};
            end
            CMD_READ: begin
                if (c.read_addr < CELLS) r.cell_data = screen[CELL_AW'(c.read_addr)];
            end
            default: ;
        endcase
        r.cursor_col    = cur_col;
        r.cursor_row    = cur_row;
        r.cursor_linear = OUT_LIN_W'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cursor_report exp_r;
        t_cursor_report act_r;
        if (!i_rst_n) begin
            foreach (screen[i]) screen[i] = '0;
            cur_col    = '0;
            cur_row    = '0;
            blank_attr = DEFAULT_ATTR_INIT;
            o_errors   = 0;
            expected_reports.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_DEFAULT_ATTR) begin
                if (i_pwrite) begin
                    blank_attr = i_pwdata[BYTE_W-1:0];
                end else if (i_prdata[BYTE_W-1:0] !== blank_attr) begin
                    $error("default_attr: expected %0d, actual %0d",
                           blank_attr, i_prdata[BYTE_W-1:0]);
                    o_errors++;
                end
            end
            if (i_cmd_tvalid && i_cmd_tready)
                expected_reports.push_back(execute_command(t_console_cmd'(i_cmd_tdata)));
            if (i_res_tvalid && i_res_tready) begin
                act_r = t_cursor_report'(i_res_tdata);
                if (expected_reports.size() == 0) begin
                    $error("unexpected result transfer: %h", i_res_tdata);
                    o_errors++;
                end else begin
                    exp_r = expected_reports.pop_front();
                    if (act_r.cursor_col !== exp_r.cursor_col) begin
                        $error("cursor_col: expected %0d, actual %0d",
                               exp_r.cursor_col, act_r.cursor_col);
                        o_errors++;
                    end
                    if (act_r.cursor_row !== exp_r.cursor_row) begin
                        $error("cursor_row: expected %0d, actual %0d",
                               exp_r.cursor_row, act_r.cursor_row);
                        o_errors++;
                    end
                    if (act_r.cursor_linear !== exp_r.cursor_linear) begin
                        $error("cursor_linear: expected %0d, actual %0d",
                               exp_r.cursor_linear, act_r.cursor_linear);
                        o_errors++;
                    end
                    if (act_r.cell_data !== exp_r.cell_data) begin
                        $error("cell_data: expected %h, actual %h",
                               exp_r.cell_data, act_r.cell_data);
                        o_errors++;
                    end
                    if (act_r.rejected !== exp_r.rejected) begin
                        $error("rejected: expected %0d, actual %0d",
                               exp_r.rejected, act_r.rejected);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

@@ dv/testbench.sv @@
// Top of the console writer bench: clock, reset, command stimulus, register setup and verdict.
`timescale 1ns / 100ps

module testbench;
    import tcw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int PHASE_ITEMS = 250;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 8;
    localparam int STALL_LIMIT = 20000;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    int errors;
    int pending;
    int snd_idle;
    int rcv_idle;
    bit hold_req;
    bit hold_done;

    text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_tvalid (s_axis_tvalid),
        .i_cmd_tready (s_axis_tready),
        .i_cmd_tdata  (s_axis_tdata),
        .i_res_tvalid (m_axis_tvalid),
        .i_res_tready (m_axis_tready),
        .i_res_tdata  (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [IN_TDATA_W-1:0] pack_command(
        logic [CMD_W-1:0] op, logic [BYTE_W-1:0] code, logic [BYTE_W-1:0] attr,
        logic [BYTE_W-1:0] col, logic [BYTE_W-1:0] row, logic [ADDR_IN_W-1:0] addr);
        return {2'b00, addr, row, col, attr, code, op};
    endfunction

    // mostly puts and cursor moves toward the bottom row so scrolls come often
    function automatic logic [IN_TDATA_W-1:0] random_console_command();
        logic [CMD_W-1:0]     op;
        logic [BYTE_W-1:0]    code;
        logic [BYTE_W-1:0]    attr;
        logic [BYTE_W-1:0]    col;
        logic [BYTE_W-1:0]    row;
        logic [ADDR_IN_W-1:0] addr;
        int                   pick;
        code = BYTE_W'($urandom);
        attr = BYTE_W'($urandom);
        col  = BYTE_W'($urandom);
        row  = BYTE_W'($urandom);
        addr = ADDR_IN_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 45) begin
            op = CMD_PUT;
            if ($urandom_range(4) == 0) code = NEWLINE_CODE;
        end else if (pick < 57) begin
            op = CMD_SET;
            if ($urandom_range(3) != 0) begin
                col = BYTE_W'($urandom_range(COLUMNS - 1));
                row = $urandom_range(1) ? BYTE_W'(ROWS - 1) :
                                          BYTE_W'($urandom_range(ROWS - 1));
            end
        end else if (pick < 67) begin
            op = CMD_ERASE;
        end else if (pick < 90) begin
            op = CMD_READ;
            if ($urandom_range(9) != 0)
                addr = ADDR_IN_W'($urandom_range(COLUMNS * ROWS - 1));
        end else if (pick < 93) begin
            op = CMD_CLEAR;
        end else begin
            op = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
        end
        return pack_command(op, code, attr, col, row, addr);
    endfunction

    task automatic send_command(input logic [IN_TDATA_W-1:0] word);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic apb_access(input logic write, input logic [BYTE_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {REG_DEFAULT_ATTR, 2'b00};
        pwdata  <= {{(APB_DATA_W - BYTE_W){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // result side: random backpressure, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable))
                stall = 0;
            else
                stall++;
            if (stall >= STALL_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [BYTE_W-1:0] attr_setting;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        snd_idle      = 20;
        rcv_idle      = 46;
        hold_req      = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    snd_idle     = 20;
                    rcv_idle     = 46;
                    attr_setting = 8'hFF;
                end
                1: begin
                    snd_idle     = 46;
                    rcv_idle     = 20;
                    attr_setting = 8'h00;
                end
                default: begin
                    snd_idle     = 0;
                    rcv_idle     = 0;
                    attr_setting = BYTE_W'($urandom);
                end
            endcase
            apb_access(1'b1, attr_setting);
            apb_access(1'b0, 8'h00);

            if (phase == 0) begin
                // reads past the store end are legal before the first clear
                send_command(pack_command(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 11'h7FF));
                send_command(pack_command(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 11'd2000));
                send_command(pack_command(CMD_PUT, 8'h41, 8'hFF, 8'h00, 8'h00, 11'h000));
                send_command(pack_command(CMD_ERASE, 8'h00, 8'h1E, 8'h00, 8'h00, 11'h000));
                send_command(pack_command(CMD_ERASE, 8'h00, 8'h2C, 8'h00, 8'h00, 11'h000));
                send_command(pack_command(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 11'h000));
                send_command(pack_command(CMD_PUT, 8'hFF, 8'h00, 8'h00, 8'h00, 11'h000));
                send_command(pack_command(CMD_PUT, 8'h00, 8'hFF, 8'h00, 8'h00, 11'h000));
                send_command(pack_command(CMD_PUT, NEWLINE_CODE, 8'h5A, 8'h00, 8'h00, 11'h000));
                send_command(pack_command(CMD_SET, 8'h00, 8'h00, 8'd79, 8'd24, 11'h000));
                send_command(pack_command(CMD_PUT, 8'h5A, 8'h71, 8'h00, 8'h00, 11'h000));
                send_command(pack_command(CMD_SET, 8'h00, 8'h00, 8'd80, 8'd0, 11'h000));
                send_command(pack_command(CMD_SET, 8'h00, 8'h00, 8'd0, 8'd25, 11'h000));
                send_command(pack_command(CMD_SET, 8'h00, 8'h00, 8'hFF, 8'hFF, 11'h000));
                send_command(pack_command(CMD_SET, 8'h00, 8'h00, 8'd0, 8'd5, 11'h000));
                send_command(pack_command(CMD_ERASE, 8'h00, 8'h9C, 8'h00, 8'h00, 11'h000));
                send_command(pack_command(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 11'd0));
                send_command(pack_command(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 11'd1999));
                send_command(pack_command(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 11'd1920));
                send_command(pack_command(CMD_SET, 8'h00, 8'h00, 8'd5, 8'd24, 11'h000));
                send_command(pack_command(CMD_PUT, NEWLINE_CODE, 8'h00, 8'h00, 8'h00, 11'h000));
                send_command(pack_command(CMD_SPARE_FIRST, 8'h00, 8'h00, 8'h00, 8'h00, 11'h0));
                send_command(pack_command(CMD_SPARE_MID, 8'h00, 8'h00, 8'h00, 8'h00, 11'h0));
                send_command(pack_command(CMD_SPARE_LAST, 8'h00, 8'h00, 8'h00, 8'h00, 11'h0));
            end
            if (phase == 2) hold_req = 1'b1;

            repeat (PHASE_ITEMS) send_command(random_console_command());
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;

            do @(negedge i_clk); while (pending != 0);
            repeat (SETTLE) @(negedge i_clk);
        end

        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_apb_regs.sv
hdl/text_console_writer.sv
dv/console_checker.sv
dv/testbench.sv
